>>> sv/mfcp_pkg.sv
// ----------------------------------------------------------------------------
// mfcp_pkg
// Shared types and constants of the media frame chunk packetizer.
// ----------------------------------------------------------------------------
package mfcp_pkg;

  localparam int CHUNK_BYTES = 16384;
  localparam int MAX_FRAME   = 2097152;
  localparam int MAX_COUNT   = 16'hffff;
  localparam int HDR_LEN     = 16;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  localparam int LEN_W = 22;
  localparam int CNT_W = 16;
  localparam int CBL_W = 17;
  localparam int ID_W  = 32;
  localparam int IDX_W = $clog2(HDR_LEN + 1);

  localparam logic [7:0] MAGIC_0  = 8'h4c;  // L
  localparam logic [7:0] MAGIC_1  = 8'h43;  // C
  localparam logic [7:0] MAGIC_2  = 8'h4d;  // M
  localparam logic [7:0] MAGIC_3  = 8'h31;  // 1
  localparam logic [7:0] TAG_V    = 8'h56;
  localparam logic [7:0] TAG_A    = 8'h41;
  localparam logic [7:0] VERSION  = 8'h01;

  typedef struct packed {
    logic             stream;
    logic             hdr;
    logic             last;
    logic [7:0]       data;
    logic [CNT_W-1:0] chunk_index;
    logic [CNT_W-1:0] chunk_total;
    logic [ID_W-1:0]  frame_id;
    logic [15:0]      chunk_len;
  } cmd_t;

endpackage

>>> sv/mfcp_front.sv
// ----------------------------------------------------------------------------
// mfcp_front
// Frame tracking: takes input beats, keeps frame and chunk state, and
// queues one command per payload byte, flagged when a header goes first.
// ----------------------------------------------------------------------------
module mfcp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic                         stream_select,
  input  logic                         frame_start,
  input  logic [mfcp_pkg::LEN_W-1:0]   frame_length,
  input  logic [7:0]                   data_byte,
  output logic                         cmd_en,
  output mfcp_pkg::cmd_t               cmd
);

  logic [mfcp_pkg::ID_W-1:0]  ctr_r [2];
  logic [mfcp_pkg::ID_W-1:0]  ctr_nxt [2];
  logic                       active_r, active_nxt;
  logic                       drop_r, drop_nxt;
  logic [mfcp_pkg::LEN_W-1:0] bl_r, bl_nxt;
  logic [mfcp_pkg::CNT_W-1:0] ci_r, ci_nxt;
  logic [mfcp_pkg::CNT_W-1:0] ct_r, ct_nxt;
  logic [mfcp_pkg::CBL_W-1:0] cbl_r, cbl_nxt;
  logic [mfcp_pkg::ID_W-1:0]  fid_r, fid_nxt;

  logic [mfcp_pkg::LEN_W:0]   count;
  logic                       emit;
  logic                       hdr;
  logic [mfcp_pkg::CBL_W-1:0] clen;
  logic [mfcp_pkg::CBL_W-1:0] cbl_after;
  logic [mfcp_pkg::LEN_W-1:0] bl_cur;
  logic [mfcp_pkg::CBL_W-1:0] cbl_cur;
  logic [mfcp_pkg::CNT_W-1:0] ct_cur;
  logic [mfcp_pkg::ID_W-1:0]  fid_cur;
  logic                       stream_cur;
  logic                       last;

  assign count = (mfcp_pkg::LEN_W+1)'(({1'b0, frame_length} +
                 (mfcp_pkg::LEN_W+1)'(mfcp_pkg::CHUNK_BYTES - 1)) / mfcp_pkg::CHUNK_BYTES);

  always_comb begin
    ctr_nxt    = ctr_r;
    active_nxt = active_r;
    drop_nxt   = drop_r;
    bl_nxt     = bl_r;
    ci_nxt     = ci_r;
    ct_nxt     = ct_r;
    cbl_nxt    = cbl_r;
    fid_nxt    = fid_r;
    emit       = 1'b0;
    bl_cur     = bl_r;
    cbl_cur    = cbl_r;
    ct_cur     = ct_r;
    fid_cur    = fid_r;
    stream_cur = active_r;
    if (frame_start) begin
      bl_nxt     = '0;
      drop_nxt   = 1'b0;
      cbl_nxt    = '0;
      ci_nxt     = '0;
      ct_nxt     = '0;
      active_nxt = stream_select;
      stream_cur = stream_select;
      if (frame_length != '0) begin
        if (frame_length > mfcp_pkg::LEN_W'(mfcp_pkg::MAX_FRAME) ||
            count > (mfcp_pkg::LEN_W+1)'(mfcp_pkg::MAX_COUNT)) begin
          bl_nxt   = frame_length - 1'b1;
          drop_nxt = (frame_length - 1'b1) != '0;
        end else begin
          fid_cur                = ctr_r[stream_select];
          fid_nxt                = ctr_r[stream_select];
          ctr_nxt[stream_select] = ctr_r[stream_select] + 1'b1;
          ct_cur                 = count[mfcp_pkg::CNT_W-1:0];
          ct_nxt                 = count[mfcp_pkg::CNT_W-1:0];
          bl_cur                 = frame_length;
          cbl_cur                = '0;
          ci_nxt                 = '0;
          emit                   = 1'b1;
        end
      end
    end else if (bl_r != '0) begin
      if (drop_r) begin
        bl_nxt = bl_r - 1'b1;
        if (bl_r == mfcp_pkg::LEN_W'(1)) begin
          drop_nxt = 1'b0;
        end
      end else begin
        emit = 1'b1;
      end
    end

    hdr       = cbl_cur == '0;
    clen      = (bl_cur < mfcp_pkg::LEN_W'(mfcp_pkg::CHUNK_BYTES)) ?
                bl_cur[mfcp_pkg::CBL_W-1:0] : mfcp_pkg::CBL_W'(mfcp_pkg::CHUNK_BYTES);
    cbl_after = (hdr ? clen : cbl_cur) - 1'b1;
    last      = cbl_after == '0;
    if (emit) begin
      cbl_nxt = cbl_after;
      bl_nxt  = bl_cur - 1'b1;
      ci_nxt  = (frame_start ? '0 : ci_r) + (mfcp_pkg::CNT_W)'(last);
    end
  end

  always_comb begin
    cmd.stream      = stream_cur;
    cmd.hdr         = hdr;
    cmd.last        = last;
    cmd.data        = data_byte;
    cmd.chunk_index = frame_start ? '0 : ci_r;
    cmd.chunk_total = ct_cur;
    cmd.frame_id    = fid_cur;
    cmd.chunk_len   = clen[15:0];
  end

  assign cmd_en = acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      active_r <= 1'b0;
      drop_r   <= 1'b0;
      bl_r     <= '0;
      ci_r     <= '0;
      ct_r     <= '0;
      cbl_r    <= '0;
      fid_r    <= '0;
    end else if (acc) begin
      ctr_r    <= ctr_nxt;
      active_r <= active_nxt;
      drop_r   <= drop_nxt;
      bl_r     <= bl_nxt;
      ci_r     <= ci_nxt;
      ct_r     <= ct_nxt;
      cbl_r    <= cbl_nxt;
      fid_r    <= fid_nxt;
    end
  end

  a_drop_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> bl_r != '0)
    else $error("dropping with no bytes left");

  a_chunk_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cbl_r != '0) |-> (bl_r != '0) && !drop_r)
    else $error("open chunk outside a frame");

endmodule

>>> sv/mfcp_queue.sv
// ----------------------------------------------------------------------------
// mfcp_queue
// Short command queue between frame tracking and packet output.
// ----------------------------------------------------------------------------
module mfcp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  mfcp_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output mfcp_pkg::cmd_t rd_data,
  output logic           empty
);

  mfcp_pkg::cmd_t             mem_r [mfcp_pkg::Q_DEPTH];
  logic [mfcp_pkg::Q_AW-1:0]  wp_r, wp_nxt;
  logic [mfcp_pkg::Q_AW-1:0]  rp_r, rp_nxt;
  logic [mfcp_pkg::Q_AW:0]    cnt_r, cnt_nxt;

  assign full    = cnt_r == (mfcp_pkg::Q_AW+1)'(mfcp_pkg::Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (mfcp_pkg::Q_AW+1)'(wr_en) - (mfcp_pkg::Q_AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("queue read while empty");

endmodule

>>> sv/mfcp_back.sv
// ----------------------------------------------------------------------------
// mfcp_back
// Packet output: turns queued commands into header and payload beats
// through a registered output stage.
// ----------------------------------------------------------------------------
module mfcp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mfcp_pkg::cmd_t q_data,
  input  logic           q_empty,
  output logic           q_rd,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_stream,
  output logic           out_packet_last
);

  mfcp_pkg::cmd_t             cmd_r, cmd_nxt;
  logic                       busy_r, busy_nxt;
  logic [mfcp_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       ov_r, ov_nxt;
  logic [7:0]                 ob_r, ob_nxt;
  logic                       os_r, os_nxt;
  logic                       ol_r, ol_nxt;

  mfcp_pkg::cmd_t             cur;
  logic                       cur_valid;
  logic                       can_load;
  logic [mfcp_pkg::IDX_W-1:0] idx;
  logic [7:0]                 beat;

  assign cur       = busy_r ? cmd_r : q_data;
  assign cur_valid = busy_r || !q_empty;
  assign can_load  = !ov_r || !out_stall;
  assign idx       = busy_r ? idx_r :
                     (q_data.hdr ? '0 : mfcp_pkg::IDX_W'(mfcp_pkg::HDR_LEN));
  assign q_rd      = can_load && !busy_r && !q_empty;

  always_comb begin
    unique case (idx)
      5'd0:    beat = mfcp_pkg::MAGIC_0;
      5'd1:    beat = mfcp_pkg::MAGIC_1;
      5'd2:    beat = mfcp_pkg::MAGIC_2;
      5'd3:    beat = mfcp_pkg::MAGIC_3;
      5'd4:    beat = cur.stream ? mfcp_pkg::TAG_A : mfcp_pkg::TAG_V;
      5'd5:    beat = mfcp_pkg::VERSION;
      5'd6:    beat = cur.chunk_index[15:8];
      5'd7:    beat = cur.chunk_index[7:0];
      5'd8:    beat = cur.chunk_total[15:8];
      5'd9:    beat = cur.chunk_total[7:0];
      5'd10:   beat = cur.frame_id[31:24];
      5'd11:   beat = cur.frame_id[23:16];
      5'd12:   beat = cur.frame_id[15:8];
      5'd13:   beat = cur.frame_id[7:0];
      5'd14:   beat = cur.chunk_len[15:8];
      5'd15:   beat = cur.chunk_len[7:0];
      default: beat = cur.data;
    endcase
  end

  always_comb begin
    cmd_nxt  = cmd_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    os_nxt   = os_r;
    ol_nxt   = ol_r;
    if (can_load) begin
      ov_nxt = cur_valid;
      if (cur_valid) begin
        ob_nxt = beat;
        os_nxt = cur.stream;
        ol_nxt = (idx == mfcp_pkg::IDX_W'(mfcp_pkg::HDR_LEN)) && cur.last;
        if (idx == mfcp_pkg::IDX_W'(mfcp_pkg::HDR_LEN)) begin
          busy_nxt = 1'b0;
        end else begin
          busy_nxt = 1'b1;
          cmd_nxt  = cur;
          idx_nxt  = idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    ob_r  <= ob_nxt;
    os_r  <= os_nxt;
    ol_r  <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_stream      = os_r;
  assign out_packet_last = ol_r;

  a_busy_idx: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r != '0 && idx_r <= mfcp_pkg::IDX_W'(mfcp_pkg::HDR_LEN))
    else $error("header index out of range");

  a_busy_holds_beat: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ov_r)
    else $error("header in progress with empty output stage");

endmodule

>>> sv/media_frame_chunk_packetizer.sv
// ----------------------------------------------------------------------------
// media_frame_chunk_packetizer
// Cuts video and audio frames into chunk packets with a 16-byte header.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one frame byte per beat. The beat with
// in_frame_start high gives the stream and frame length and, for a nonzero
// length, the first byte. Empty or oversized frames are swallowed.
// Output channel (out_valid / out_stall): one packet byte per beat, header
// bytes first, out_packet_last on the final payload byte of each chunk.
// An accepted beat is written into the command queue at once; the output stage
// then loads its first output beat from the queue into the output register.
// Throughput: one input beat per cycle while no header is sent and while the
// queue is not full; a chunk opener adds 16 header bytes on the byte lane.
// A four-entry command queue sits between the frame tracker and the output
// stage, so in_stall rises only when that queue is full.
// Receiver stall: the output register holds its beat; the queue fills and
// then stalls the input.
// Reset (rst_n low, synchronous): frame ids of both streams restart at zero,
// any frame in progress is dropped and the queue and output are emptied.
// ----------------------------------------------------------------------------
module media_frame_chunk_packetizer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_stream_select,
  input  logic                       in_frame_start,
  input  logic [mfcp_pkg::LEN_W-1:0] in_frame_length,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_stream,
  output logic                       out_packet_last
);

  logic           acc;
  logic           cmd_en;
  mfcp_pkg::cmd_t cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_rd;
  mfcp_pkg::cmd_t q_data;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  mfcp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .stream_select (in_stream_select),
    .frame_start   (in_frame_start),
    .frame_length  (in_frame_length),
    .data_byte     (in_data_byte),
    .cmd_en        (cmd_en),
    .cmd           (cmd)
  );

  mfcp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_en),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  mfcp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_data),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_stream      (out_stream),
    .out_packet_last (out_packet_last)
  );

endmodule

>>> bench/tb_media_frame_chunk_packetizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_media_frame_chunk_packetizer
// Self-checking bench for the media frame chunk packetizer. A queue of frame
// beats (directed corner frames, then random frames with truncated, empty,
// oversized and stray beats) feeds a clocked driver. Each accepted input beat
// runs through an in-bench packet model whose expected output beats are
// compared field by field against the output channel.
// Both sides idle at random; the receiver also holds off once for a long
// stretch and the sender pauses a few times until the output has drained.
// ----------------------------------------------------------------------------
module tb_media_frame_chunk_packetizer;

  localparam int STREAM_VIDEO = 0;
  localparam int STREAM_AUDIO = 1;
  localparam int FULL_LEN     = (1 << mfcp_pkg::LEN_W) - 1;
  localparam int RAND_ITEMS   = 250;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic                       sel;
    logic                       start;
    logic [mfcp_pkg::LEN_W-1:0] len;
    logic [7:0]                 data;
    logic                       drain;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       stream;
    logic       eop;
  } pkt_beat_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_stream_select = 1'b0;
  logic                       in_frame_start = 1'b0;
  logic [mfcp_pkg::LEN_W-1:0] in_frame_length = '0;
  logic [7:0]                 in_data_byte = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 out_byte;
  logic                       out_stream;
  logic                       out_packet_last;

  media_frame_chunk_packetizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_stream_select(in_stream_select),
    .in_frame_start  (in_frame_start),
    .in_frame_length (in_frame_length),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_stream      (out_stream),
    .out_packet_last (out_packet_last)
  );

  frame_item_t pending_beats[$];
  pkt_beat_t   packet_beats_q[$];
  frame_item_t cur_item;
  pkt_beat_t   oldest_beat;

  // packet model state
  logic [mfcp_pkg::ID_W-1:0]  next_frame_id[2];
  logic                       act_stream;
  logic                       drop_frame;
  logic [mfcp_pkg::LEN_W-1:0] frame_left;
  logic [mfcp_pkg::CNT_W-1:0] chunk_idx;
  logic [mfcp_pkg::CNT_W-1:0] chunk_cnt;
  logic [mfcp_pkg::CBL_W-1:0] chunk_left;
  logic [mfcp_pkg::ID_W-1:0]  frame_id;

  int unsigned cyc = 0;
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int frames_taken = 0;
  int headers_sent = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int planned = 0;
  int len_pick;
  int cut;
  int r;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit idle_now();
    if (cyc >= 150 && cyc < 450) return 1'b0;
    return $urandom_range(0, 99) < 19;
  endfunction

  function automatic void push_beat(logic [7:0] b, logic eop);
    pkt_beat_t pb;
    pb.pbyte  = b;
    pb.stream = act_stream;
    pb.eop    = eop;
    packet_beats_q.insert(packet_beats_q.size(), pb);
  endfunction

  function automatic void packetize_beat(frame_item_t it);
    int len;
    int count;
    int clen;
    logic [7:0] hdr[16];
    if (it.start) begin
      frame_left = '0;
      drop_frame = 1'b0;
      chunk_left = '0;
      chunk_idx  = '0;
      chunk_cnt  = '0;
      act_stream = it.sel;
      len = int'(it.len);
      if (len == 0) return;
      count = (len + mfcp_pkg::CHUNK_BYTES - 1) / mfcp_pkg::CHUNK_BYTES;
      if (len > mfcp_pkg::MAX_FRAME || count > mfcp_pkg::MAX_COUNT) begin
        frame_left = mfcp_pkg::LEN_W'(len - 1);
        drop_frame = frame_left != 0;
        return;
      end
      frame_id = next_frame_id[it.sel];
      next_frame_id[it.sel] = next_frame_id[it.sel] + 1'b1;
      chunk_cnt  = mfcp_pkg::CNT_W'(count);
      frame_left = mfcp_pkg::LEN_W'(len);
      frames_taken++;
    end else begin
      if (frame_left == 0) return;
      if (drop_frame) begin
        frame_left = frame_left - 1'b1;
        if (frame_left == 0) drop_frame = 1'b0;
        return;
      end
    end
    if (chunk_left == 0) begin
      clen = (frame_left < mfcp_pkg::CHUNK_BYTES) ? int'(frame_left) : mfcp_pkg::CHUNK_BYTES;
      hdr[0]  = mfcp_pkg::MAGIC_0;
      hdr[1]  = mfcp_pkg::MAGIC_1;
      hdr[2]  = mfcp_pkg::MAGIC_2;
      hdr[3]  = mfcp_pkg::MAGIC_3;
      hdr[4]  = (act_stream == 1'(STREAM_AUDIO)) ? mfcp_pkg::TAG_A : mfcp_pkg::TAG_V;
      hdr[5]  = mfcp_pkg::VERSION;
      hdr[6]  = chunk_idx[15:8];
      hdr[7]  = chunk_idx[7:0];
      hdr[8]  = chunk_cnt[15:8];
      hdr[9]  = chunk_cnt[7:0];
      hdr[10] = frame_id[31:24];
      hdr[11] = frame_id[23:16];
      hdr[12] = frame_id[15:8];
      hdr[13] = frame_id[7:0];
      hdr[14] = clen[15:8];
      hdr[15] = clen[7:0];
      for (int i = 0; i < mfcp_pkg::HDR_LEN; i++) push_beat(hdr[i], 1'b0);
      chunk_left = mfcp_pkg::CBL_W'(clen);
      headers_sent++;
    end
    chunk_left = chunk_left - 1'b1;
    frame_left = frame_left - 1'b1;
    push_beat(it.data, chunk_left == 0);
    if (chunk_left == 0) chunk_idx = chunk_idx + 1'b1;
  endfunction

  task automatic add_item(int sel, int start, int len, int data);
    frame_item_t it;
    it.sel   = 1'(sel);
    it.start = 1'(start);
    it.len   = mfcp_pkg::LEN_W'(len);
    it.data  = 8'(data);
    it.drain = 1'b0;
    pending_beats.insert(pending_beats.size(), it);
  endtask

  task automatic add_drain();
    frame_item_t it;
    it = '{default: '0};
    it.drain = 1'b1;
    pending_beats.insert(pending_beats.size(), it);
  endtask

  // start beat plus nbytes-1 body beats; stream select on body beats is noise
  task automatic add_frame(int sel, int len, int nbytes);
    add_item(sel, 1, len, $urandom_range(0, 255));
    for (int i = 1; i < nbytes; i++)
      add_item($urandom_range(0, 1), 0, $urandom_range(0, FULL_LEN), $urandom_range(0, 255));
  endtask

  task automatic report(string what, int expv, int actv);
    errors++;
    $display("%0t: %s expected %0h actual %0h", $time, what, expv, actv);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        packetize_beat(cur_item);
        beats_in++;
      end
      if (pending_beats.size() > 0 && pending_beats[0].drain) begin
        if (packet_beats_q.size() == 0) void'(pending_beats.pop_front());
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0 && !idle_now()) begin
        cur_item = pending_beats.pop_front();
        in_stream_select <= cur_item.sel;
        in_frame_start   <= cur_item.start;
        in_frame_length  <= cur_item.len;
        in_data_byte     <= cur_item.data;
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (packet_beats_q.size() == 0) begin
          report("unexpected beat, byte", 0, int'(out_byte));
        end else begin
          oldest_beat = packet_beats_q.pop_front();
          if (out_byte !== oldest_beat.pbyte)
            report("out_byte", int'(oldest_beat.pbyte), int'(out_byte));
          if (out_stream !== oldest_beat.stream)
            report("out_stream", int'(oldest_beat.stream), int'(out_stream));
          if (out_packet_last !== oldest_beat.eop)
            report("out_packet_last", int'(oldest_beat.eop), int'(out_packet_last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && beats_out >= 150) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("media_frame_chunk_packetizer: mismatch");
    $finish;
  end

  initial begin
    next_frame_id[0] = '0;
    next_frame_id[1] = '0;
    act_stream = 1'b0;
    drop_frame = 1'b0;
    frame_left = '0;
    chunk_idx  = '0;
    chunk_cnt  = '0;
    chunk_left = '0;
    frame_id   = '0;

    // directed corners
    add_item(STREAM_AUDIO, 0, FULL_LEN, 'hff);
    add_item(STREAM_VIDEO, 1, 0, 'h00);
    add_item(STREAM_AUDIO, 1, 0, 'hff);
    add_item(STREAM_VIDEO, 1, 1, 'h00);
    add_item(STREAM_AUDIO, 1, 1, 'hff);
    add_frame(STREAM_VIDEO, 3, 3);
    add_item(STREAM_VIDEO, 0, 0, 'h5a);
    add_frame(STREAM_AUDIO, FULL_LEN, 3);
    add_frame(STREAM_VIDEO, mfcp_pkg::MAX_FRAME + 1, 2);
    add_frame(STREAM_AUDIO, mfcp_pkg::MAX_FRAME, 3);
    add_frame(STREAM_VIDEO, 5, 2);
    add_frame(STREAM_AUDIO, 2, 2);
    add_drain();

    // random frames, mostly complete
    while (planned < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        add_frame($urandom_range(0, 1), len_pick, len_pick);
        planned += len_pick;
      end else if (r < 80) begin
        cut = $urandom_range(1, 5);
        add_frame($urandom_range(0, 1), $urandom_range(0, FULL_LEN), cut);
        planned += cut;
      end else if (r < 86) begin
        add_item($urandom_range(0, 1), 1, 0, $urandom_range(0, 255));
        planned++;
      end else if (r < 94) begin
        add_item($urandom_range(0, 1), 0, $urandom_range(0, FULL_LEN), $urandom_range(0, 255));
        planned++;
      end else begin
        add_drain();
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (packet_beats_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d input beats, %0d frames accepted, %0d chunk headers, %0d output beats",
             beats_in, frames_taken, headers_sent, beats_out);
    $display("with empty, oversized and cut-off frames, a long receiver hold-off and drains");
    if (errors == 0 && packet_beats_q.size() == 0) begin
      $display("media_frame_chunk_packetizer: match");
    end else begin
      $display("media_frame_chunk_packetizer: mismatch");
    end
    $finish;
  end

endmodule
